// ===== rtl/vis_pkg.sv =====
// Shared types and constants for the vector inclusive scan core.
package vis_pkg;

  // Word width of one lane.
  localparam int unsigned WORD_W = 32;

  // Physical lane count of the vector ports.
  localparam int unsigned MAX_LANES = 8;

  // Active lanes; result lanes at and above this count read as zero.
  localparam int unsigned LANE_COUNT = 8;

  // Number of log-step scan levels, one pipeline stage each.
  localparam int unsigned LEVEL_COUNT = $clog2(MAX_LANES);

  typedef logic signed [WORD_W-1:0] word_t;
  typedef word_t [MAX_LANES-1:0] vec_t;

  // Scan operator codes.
  typedef enum logic [1:0] {
    OP_SUM     = 2'd0,
    OP_PRODUCT = 2'd1,
    OP_MAXIMUM = 2'd2,
    OP_MINIMUM = 2'd3
  } op_t;

endpackage

// ===== rtl/vis_combine.sv =====
// Combine unit: applies one scan operator to an earlier and a later lane value.
module vis_combine (
  input  vis_pkg::op_t  operation,
  input  vis_pkg::word_t lo,
  input  vis_pkg::word_t hi,
  output vis_pkg::word_t result
);
  import vis_pkg::*;

  word_t sum;
  word_t product;

  // Sum and product keep the low word, so signedness does not matter here.
  assign sum     = lo + hi;
  assign product = lo * hi;

  // Select the operator; maximum and minimum compare as signed values.
  always_comb begin
    unique case (operation)
      OP_SUM:     result = sum;
      OP_PRODUCT: result = product;
      OP_MAXIMUM: result = (lo > hi) ? lo : hi;
      OP_MINIMUM: result = (hi > lo) ? lo : hi;
      default:    result = sum;
    endcase
  end

endmodule

// ===== rtl/vector_inclusive_scan_core.sv =====
// Top level of the vector inclusive scan core: a pipelined log-step prefix scan.
//
// The core takes one item per cycle while not stalled: an operation code (sum,
// product, maximum, minimum) and eight signed 32-bit lanes, and returns scan_i =
// lane_0 op ... op lane_i. The scan is built as a log-step network: level k
// combines each lane with the lane 2^k below it, and each of the three levels is
// one register stage holding one combine unit (adder, multiplier and signed
// compare) per lane at or above the stride. An accepted item passes through
// stage 0, stage 1 and stage 2 in order; its result is valid once it is loaded
// into the last stage. The sustained rate is one item per cycle while the output
// is not stalled. Sums and products wrap modulo 2^32. A stall on the output holds
// each occupied stage with no empty stage after it, while the others still move
// on, so in_stall rises only when the first stage is full and cannot move on.
module vector_inclusive_scan_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  vis_pkg::op_t  operation,
  input  vis_pkg::word_t lane_0,
  input  vis_pkg::word_t lane_1,
  input  vis_pkg::word_t lane_2,
  input  vis_pkg::word_t lane_3,
  input  vis_pkg::word_t lane_4,
  input  vis_pkg::word_t lane_5,
  input  vis_pkg::word_t lane_6,
  input  vis_pkg::word_t lane_7,
  output logic          out_valid,
  input  logic          out_stall,
  output vis_pkg::word_t scan_0,
  output vis_pkg::word_t scan_1,
  output vis_pkg::word_t scan_2,
  output vis_pkg::word_t scan_3,
  output vis_pkg::word_t scan_4,
  output vis_pkg::word_t scan_5,
  output vis_pkg::word_t scan_6,
  output vis_pkg::word_t scan_7
);
  import vis_pkg::*;

  localparam int unsigned LAST = LEVEL_COUNT - 1;

  vec_t                   in_vec;
  vec_t                   out_vec;
  vec_t                   level_in   [LEVEL_COUNT];
  vec_t                   level_out  [LEVEL_COUNT];
  op_t                    level_op   [LEVEL_COUNT];
  vec_t                   stage_data [LEVEL_COUNT];
  op_t                    stage_op   [LEVEL_COUNT];
  logic [LEVEL_COUNT-1:0] stage_valid;
  logic [LEVEL_COUNT-1:0] stage_adv;

  // Gather the input lanes into one vector.
  assign in_vec = {lane_7, lane_6, lane_5, lane_4, lane_3, lane_2, lane_1, lane_0};

  // Each stage moves on when it is empty or the stage after it moves on.
  always_comb begin
    stage_adv[LAST] = !stage_valid[LAST] || !out_stall;
    for (int s = LAST - 1; s >= 0; s--) begin
      stage_adv[s] = !stage_valid[s] || stage_adv[s + 1];
    end
  end

  assign in_stall  = !stage_adv[0];
  assign out_valid = stage_valid[LAST];

  // Scan network: level k combines lane i with lane i - 2^k.
  for (genvar k = 0; k < LEVEL_COUNT; k++) begin : g_level
    localparam int unsigned STRIDE = 1 << k;

    if (k == 0) begin : g_first
      assign level_in[k] = in_vec;
      assign level_op[k] = operation;
    end else begin : g_next
      assign level_in[k] = stage_data[k - 1];
      assign level_op[k] = stage_op[k - 1];
    end

    for (genvar i = 0; i < MAX_LANES; i++) begin : g_lane
      if (i >= STRIDE) begin : g_comb
        vis_combine u_combine (
          .operation (level_op[k]),
          .lo        (level_in[k][i - STRIDE]),
          .hi        (level_in[k][i]),
          .result    (level_out[k][i])
        );
      end else begin : g_pass
        assign level_out[k][i] = level_in[k][i];
      end
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_adv[0]) begin
        stage_valid[0] <= in_valid;
      end
      for (int s = 1; s < LEVEL_COUNT; s++) begin
        if (stage_adv[s]) begin
          stage_valid[s] <= stage_valid[s - 1];
        end
      end
    end
  end

  // Stage payload registers load whenever their stage moves on.
  always_ff @(posedge clk) begin
    for (int s = 0; s < LEVEL_COUNT; s++) begin
      if (stage_adv[s]) begin
        stage_data[s] <= level_out[s];
        stage_op[s]   <= level_op[s];
      end
    end
  end

  // Lanes at and above the active lane count read as zero.
  for (genvar i = 0; i < MAX_LANES; i++) begin : g_out
    if (i < LANE_COUNT) begin : g_active
      assign out_vec[i] = stage_data[LAST][i];
    end else begin : g_idle
      assign out_vec[i] = '0;
    end
  end

  assign scan_0 = out_vec[0];
  assign scan_1 = out_vec[1];
  assign scan_2 = out_vec[2];
  assign scan_3 = out_vec[3];
  assign scan_4 = out_vec[4];
  assign scan_5 = out_vec[5];
  assign scan_6 = out_vec[6];
  assign scan_7 = out_vec[7];

endmodule
